>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DHOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DHOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dhot_pkg.sv
// Types and constants of the double-hashing key/value table.
`timescale 1ns / 1ps

package dhot_pkg;

    // Widths of the request and response payloads.
    localparam int KEY_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Key remainder is worked out one nibble per cycle.
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_CNT_W = 3;
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST = DIGIT_CNT_W'(KEY_W / DIGIT_W - 1);

    // Result value returned on a miss and on every insert.
    localparam logic signed [KEY_W-1:0] MISS_VALUE = -32'sd777777777;

    // Request operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2
    } t_func;

    // Response status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_wr;
        logic    take_req;
        logic    mod_step;
        logic    set_probe;
        logic    advance;
        logic    finish;
        logic    fin_hit;
        logic    wr_insert;
        logic    wr_tomb;
        t_status fin_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              mod_done;
        logic              clr_last;
        logic [FUNC_W-1:0] func;
        logic              slot_used;
        logic              slot_tomb;
        logic              key_eq;
        logic              probe_last;
        logic              out_free;
    } t_stat;

endpackage

>>> src/dhot_if.sv
// Request and response channel interfaces of the hash table.
`timescale 1ns / 1ps

interface dhot_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface dhot_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [4:0]         entry_count;

    modport source (output valid, output status, output result_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input result_value, input entry_count,
                    output ready);
endinterface

>>> src/dhot_ctrl.sv
// Controller state machine of the hash table: clearing, hashing and probing.
`timescale 1ns / 1ps

module dhot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  dhot_pkg::t_stat i_stat,
    output dhot_pkg::t_cmd  o_cmd
);
    import dhot_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // A new request is taken only when no other is in flight.
    assign o_req_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        logic    fin;
        logic    adv;
        logic    hit;
        logic    ins;
        logic    tomb;
        t_status st;

        fin     = 1'b0;
        adv     = 1'b0;
        hit     = 1'b0;
        ins     = 1'b0;
        tomb    = 1'b0;
        st      = ST_NOT_FOUND;
        o_cmd   = '0;
        n_state = r_state;

        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.mod_done) begin
                    o_cmd.set_probe = 1'b1;
                    n_state         = S_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // Judge the slot just read.
                case (t_func'(i_stat.func))
                    FUNC_INSERT: begin
                        if (!i_stat.slot_used || i_stat.slot_tomb) begin
                            fin = 1'b1;
                            ins = 1'b1;
                            st  = ST_OK;
                        end else if (i_stat.probe_last) begin
                            fin = 1'b1;
                            st  = ST_FULL;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    FUNC_LOOKUP, FUNC_REMOVE: begin
                        if (!i_stat.slot_used) begin
                            fin = 1'b1;
                        end else if (!i_stat.slot_tomb && i_stat.key_eq) begin
                            fin  = 1'b1;
                            hit  = 1'b1;
                            st   = ST_OK;
                            tomb = (t_func'(i_stat.func) == FUNC_REMOVE);
                        end else if (i_stat.probe_last) begin
                            fin = 1'b1;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase

                // Finish only once the response register can take the result.
                if (fin) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_hit    = hit;
                        o_cmd.wr_insert  = ins;
                        o_cmd.wr_tomb    = tomb;
                        o_cmd.fin_status = st;
                        n_state          = S_IDLE;
                    end
                end else if (adv) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/dhot_dpath.sv
// Datapath of the hash table: request registers, key hashing, slot memory and response register.
`timescale 1ns / 1ps

module dhot_dpath #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dhot_pkg::t_cmd       i_cmd,
    output dhot_pkg::t_stat      o_stat,
    input  logic [1:0]           i_func,
    input  logic signed [31:0]   i_key,
    input  logic signed [31:0]   i_value,
    input  logic                 i_rsp_ready,
    output logic                 o_rsp_valid,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_result_value,
    output logic [4:0]           o_entry_count
);
    import dhot_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int MW = 2 + 2 * KEY_W;
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [AW:0]   SIZE_W   = (AW + 1)'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    // Request registers.
    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_value;

    // Remainder unit.
    logic [AW-1:0]          r_mod;
    logic [AW-1:0]          n_mod;
    logic [KEY_W-1:0]       r_sh;
    logic [DIGIT_CNT_W-1:0] r_dig;
    logic                   r_mod_done;
    logic [AW-1:0]          rem;

    // Probe walk.
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_step;
    logic [AW-1:0] r_n;
    logic [AW-1:0] start_pos;
    logic [AW-1:0] start_step;
    logic [AW-1:0] next_pos;
    logic [AW:0]   odd;
    logic [AW:0]   sum;

    // Slot memory.
    logic [MW-1:0]    mem [TABLE_SIZE];
    logic [MW-1:0]    r_rd;
    logic [AW-1:0]    r_clr;
    logic             we;
    logic [AW-1:0]    wa;
    logic [MW-1:0]    wd;
    logic             rd_used;
    logic             rd_tomb;
    logic [KEY_W-1:0] rd_key;
    logic [KEY_W-1:0] rd_val;

    // Live count and response register.
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [KEY_W-1:0]   r_res;
    logic [COUNT_W-1:0] r_ecount;

    // One nibble of restoring remainder per cycle, most significant first.
    always_comb begin
        logic [AW:0] m;
        m = {1'b0, r_mod};
        for (int i = 0; i < DIGIT_W; i++) begin
            m = {m[AW-1:0], r_sh[KEY_W-1-i]};
            if (m >= SIZE_W) begin
                m = m - SIZE_W;
            end
        end
        n_mod = m[AW-1:0];
    end

    // A power-of-two size takes the low key bits directly.
    assign rem = IS_POW2 ? r_key[AW-1:0] : r_mod;

    // Start slot is the negated remainder; step is the remainder made odd.
    assign start_pos  = (rem == '0) ? '0 : AW'(SIZE_W - {1'b0, rem});
    assign odd        = {1'b0, rem} | (AW + 1)'(1);
    assign start_step = (odd == SIZE_W) ? AW'(1) : odd[AW-1:0];

    // Next slot on the path, wrapped once.
    always_comb begin
        sum = {1'b0, r_pos} + {1'b0, r_step};
        if (sum >= SIZE_W) begin
            sum = sum - SIZE_W;
        end
        next_pos = sum[AW-1:0];
    end

    // Fields of the slot just read.
    assign rd_used = r_rd[MW-1];
    assign rd_tomb = r_rd[MW-2];
    assign rd_key  = r_rd[2*KEY_W-1:KEY_W];
    assign rd_val  = r_rd[KEY_W-1:0];

    // Memory write: clearing pass, new entry, or tombstone.
    always_comb begin
        we = 1'b0;
        wa = r_pos;
        wd = '0;
        if (i_cmd.clr_wr) begin
            we = 1'b1;
            wa = r_clr;
        end else if (i_cmd.finish && i_cmd.wr_insert) begin
            we = 1'b1;
            wd = {1'b1, 1'b0, r_key, r_value};
        end else if (i_cmd.finish && i_cmd.wr_tomb) begin
            we = 1'b1;
            wd = {1'b1, 1'b1, rd_key, rd_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[r_pos];
    end

    // Live count after the finishing operation.
    always_comb begin
        n_count = r_count;
        if (i_cmd.wr_insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.wr_tomb && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end
    end

    // Payload registers of the request, remainder unit and probe walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
            r_sh    <= i_key;
            r_mod   <= '0;
        end else if (i_cmd.mod_step) begin
            r_sh  <= r_sh << DIGIT_W;
            r_mod <= n_mod;
        end
        if (i_cmd.set_probe) begin
            r_pos  <= start_pos;
            r_step <= start_step;
            r_n    <= '0;
        end else if (i_cmd.advance) begin
            r_pos <= next_pos;
            r_n   <= r_n + AW'(1);
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.fin_status;
            r_res    <= i_cmd.fin_hit ? rd_val : MISS_VALUE;
            r_ecount <= COUNT_W'(n_count);
        end
    end

    // Control registers: digit counter, clear counter, count and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig       <= '0;
            r_mod_done  <= 1'b0;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_req) begin
                r_dig      <= '0;
                r_mod_done <= 1'b0;
            end else if (i_cmd.mod_step) begin
                r_dig      <= r_dig + DIGIT_CNT_W'(1);
                r_mod_done <= (r_dig == DIGIT_LAST);
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.mod_done   = IS_POW2 || r_mod_done;
        o_stat.clr_last   = (r_clr == LAST_IDX);
        o_stat.func       = r_func;
        o_stat.slot_used  = rd_used;
        o_stat.slot_tomb  = rd_tomb;
        o_stat.key_eq     = (rd_key == r_key);
        o_stat.probe_last = (r_n == LAST_IDX);
        o_stat.out_free   = !r_out_valid || i_rsp_ready;
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_res;
    assign o_entry_count  = r_ecount;

endmodule

>>> src/double_hash_open_address_table_top.sv
// Top level of the double-hashing open-addressing key/value table.
//
//   channel   direction   payload                                   transfer when
//   i_req     in          func, key, value                          valid && ready
//   o_rsp     out         status, result_value, entry_count         valid && ready
//
// After reset every slot of the memory is cleared in turn; no request is taken then.
// A request is accepted, then hashed (directly for a power-of-two size, otherwise
// one key nibble a cycle), then each slot probed is read and then checked, the
// slot memory being read once per probe. Up to TABLE_SIZE probes are made.
// One request is in flight at a time; the result register holds a response while
// the next request is accepted and hashed, and the probe walk stalls on its final
// slot until the response register is free.
`timescale 1ns / 1ps

module double_hash_open_address_table_top #(
    parameter int TABLE_SIZE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dhot_req_if.sink   i_req,
    dhot_rsp_if.source o_rsp
);
    import dhot_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing of each request.
    dhot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hashing, slot storage and response register.
    dhot_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_req.func),
        .i_key          (i_req.key),
        .i_value        (i_req.value),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_result_value (o_rsp.result_value),
        .o_entry_count  (o_rsp.entry_count)
    );

endmodule

>>> src/dhot_checker.sv
// Port-level checks of the hash table and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dhot_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [1:0]         i_rsp_status,
    input logic signed [31:0] i_rsp_result_value,
    input logic [4:0]         i_rsp_entry_count
);
    import dhot_pkg::*;

    // Only one request is worked on at a time.
    `DHOT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request accepted while another is in flight")

    // Any failed operation returns the miss value.
    `DHOT_ASSERT_NOW(a_miss_value, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != ST_OK), i_rsp_result_value == MISS_VALUE, "failed operation without miss value")

    // A stalled response keeps its payload.
    `DHOT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_result_value) && $stable(i_rsp_entry_count), "stalled response changed")

endmodule

bind double_hash_open_address_table_top dhot_checker u_dhot_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_result_value (o_rsp.result_value),
    .i_rsp_entry_count  (o_rsp.entry_count)
);

>>> bench/double_hash_open_address_table_top_tb.sv
// Self-checking testbench for the double-hashing key/value table top level.
`timescale 1ns / 1ps

module double_hash_open_address_table_top_tb;
    import dhot_pkg::*;

    localparam int unsigned SLOTS     = 16;
    localparam int unsigned POOL_SIZE = 24;
    localparam int unsigned MAIN_CNT  = 1700;
    localparam int unsigned TAIL_CNT  = 225;
    localparam int unsigned DRAIN_CYC = 100;
    localparam int unsigned SHOW_MAX  = 10;

    // Operation code outside the defined set; the table must answer it with a miss and leave its slots unchanged.
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] ALL_ONE = 32'hFFFF_FFFF;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  value;
    } t_request;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   result_value;
        logic [COUNT_W-1:0] entry_count;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dhot_req_if req_bus ();
    dhot_rsp_if rsp_bus ();

    double_hash_open_address_table_top #(
        .TABLE_SIZE(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    // Requests waiting to be driven and responses still owed by the table.
    t_request  send_q[$];
    t_response owed_q[$];

    int unsigned error_cnt  = 0;
    bit          quiet_tail = 1'b0;
    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;

    // Shadow copy of the slot array.
    bit                 shadow_used [SLOTS];
    bit                 shadow_tomb [SLOTS];
    logic [KEY_W-1:0]   shadow_key  [SLOTS];
    logic [KEY_W-1:0]   shadow_val  [SLOTS];
    logic [COUNT_W-1:0] shadow_live = '0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it must produce.
    function automatic t_response table_apply(t_request rq);
        int unsigned pos;
        int unsigned stride;
        int          hit;
        t_response   rs;
        pos    = (SLOTS - (rq.key % SLOTS)) % SLOTS;
        stride = ((rq.key % SLOTS) | 1) % SLOTS;
        if (stride == 0) begin
            stride = 1;
        end
        hit             = -1;
        rs.func         = rq.func;
        rs.key          = rq.key;
        rs.status       = ST_NOT_FOUND;
        rs.result_value = MISS_VALUE;
        if (rq.func == FUNC_INSERT) begin
            rs.status = ST_FULL;
            for (int unsigned n = 0; n < SLOTS; n++) begin
                if (!shadow_used[pos] || shadow_tomb[pos]) begin
                    shadow_used[pos] = 1'b1;
                    shadow_tomb[pos] = 1'b0;
                    shadow_key[pos]  = rq.key;
                    shadow_val[pos]  = rq.value;
                    shadow_live      = shadow_live + 1'b1;
                    rs.status        = ST_OK;
                    break;
                end
                pos = (pos + stride) % SLOTS;
            end
        end else if (rq.func == FUNC_LOOKUP || rq.func == FUNC_REMOVE) begin
            // Walk past tombstones, stop at the first never-used slot.
            for (int unsigned n = 0; n < SLOTS; n++) begin
                if (!shadow_used[pos]) begin
                    break;
                end
                if (!shadow_tomb[pos] && shadow_key[pos] == rq.key) begin
                    hit = pos;
                    break;
                end
                pos = (pos + stride) % SLOTS;
            end
            if (hit >= 0) begin
                rs.status       = ST_OK;
                rs.result_value = shadow_val[hit];
                if (rq.func == FUNC_REMOVE) begin
                    shadow_tomb[hit] = 1'b1;
                    if (shadow_live != 0) begin
                        shadow_live = shadow_live - 1'b1;
                    end
                end
            end
        end
        rs.entry_count = shadow_live;
        return rs;
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                 logic [KEY_W-1:0] value);
        t_request rq;
        rq.func  = func;
        rq.key   = key;
        rq.value = value;
        send_q.push_back(rq);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 75) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [KEY_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            3: return ALL_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic in chunks; each chunk leans toward filling or draining the table.
    task automatic queue_random(int unsigned count);
        int unsigned ins_pct;
        int unsigned roll;
        logic [FUNC_W-1:0] func;
        ins_pct = 40;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 20;
                    1: ins_pct = 40;
                    default: ins_pct = 60;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                func = FUNC_UNKNOWN;
            end else if (roll < 3 + ins_pct) begin
                func = FUNC_INSERT;
            end else if (roll < 3 + ins_pct + (97 - ins_pct) / 2) begin
                func = FUNC_LOOKUP;
            end else begin
                func = FUNC_REMOVE;
            end
            queue_request(func, pick_key(), pick_value());
        end
    endtask

    // Request driver: presents queued requests, with random idle bursts.
    always @(posedge i_clk) begin : drive_proc
        t_request rq;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_idle = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                rq.func  = req_bus.func;
                rq.key   = req_bus.key;
                rq.value = req_bus.value;
                owed_q.push_back(table_apply(rq));
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (send_idle > 0) begin
                    send_idle = send_idle - 1;
                    req_bus.valid <= 1'b0;
                end else if (send_q.size() == 0) begin
                    req_bus.valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 99) < 10) begin
                    send_idle = $urandom_range(1, 19) - 1;
                    req_bus.valid <= 1'b0;
                end else begin
                    rq = send_q.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.func  <= rq.func;
                    req_bus.key   <= rq.key;
                    req_bus.value <= rq.value;
                end
            end
        end
    end

    // Response monitor: checks each transfer against the oldest owed response.
    always @(posedge i_clk) begin : watch_proc
        t_response exp;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (owed_q.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= SHOW_MAX) begin
                        $display("unexpected response: status %0d value %h count %0d",
                                 rsp_bus.status, rsp_bus.result_value, rsp_bus.entry_count);
                    end
                end else begin
                    exp = owed_q.pop_front();
                    if (rsp_bus.status !== exp.status
                            || rsp_bus.result_value !== exp.result_value
                            || rsp_bus.entry_count !== exp.entry_count) begin
                        error_cnt++;
                        if (error_cnt <= SHOW_MAX) begin
                            $display("mismatch func %0d key %h: expected %0d/%h/%0d got %0d/%h/%0d",
                                     exp.func, exp.key,
                                     exp.status, exp.result_value, exp.entry_count,
                                     rsp_bus.status, rsp_bus.result_value,
                                     rsp_bus.entry_count);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                rsp_bus.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < 8) begin
                recv_stall = $urandom_range(1, 19) - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Reset, stimulus and end of run.
    initial begin
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.func  = FUNC_INSERT;
        req_bus.key   = '0;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
        for (int unsigned s = 0; s < SLOTS; s++) begin
            shadow_used[s] = 1'b0;
            shadow_tomb[s] = 1'b0;
        end
        for (int unsigned p = 0; p < POOL_SIZE; p++) begin
            // Half of the pool shares one of four low nibbles, so probe paths collide.
            if (p % 2 == 0) begin
                case ($urandom_range(0, 3))
                    0: key_pool[p] = {28'($urandom), 4'h0};
                    1: key_pool[p] = {28'($urandom), 4'h1};
                    2: key_pool[p] = {28'($urandom), 4'h7};
                    default: key_pool[p] = {28'($urandom), 4'hF};
                endcase
            end else begin
                key_pool[p] = $urandom;
            end
        end
        key_pool[0] = '0;
        key_pool[1] = ALL_ONE;
        key_pool[2] = KEY_MIN;
        key_pool[3] = KEY_MAX;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: misses on an empty table, the unknown operation, extreme keys
        // and values, duplicate keys, tombstone reuse, then a full table.
        queue_request(FUNC_LOOKUP, 32'd5, '0);
        queue_request(FUNC_REMOVE, 32'd5, '0);
        queue_request(FUNC_UNKNOWN, 32'd5, ALL_ONE);
        queue_request(FUNC_INSERT, KEY_MIN, KEY_MAX);
        queue_request(FUNC_INSERT, KEY_MAX, KEY_MIN);
        queue_request(FUNC_INSERT, '0, '0);
        queue_request(FUNC_INSERT, ALL_ONE, ALL_ONE);
        queue_request(FUNC_INSERT, 32'h10, 32'd1);
        queue_request(FUNC_INSERT, 32'h10, 32'd2);
        queue_request(FUNC_LOOKUP, 32'h10, '0);
        queue_request(FUNC_REMOVE, 32'h10, '0);
        queue_request(FUNC_LOOKUP, 32'h10, '0);
        queue_request(FUNC_INSERT, 32'h20, 32'd3);
        for (int unsigned i = 0; i < 11; i++) begin
            queue_request(FUNC_INSERT, $urandom, $urandom);
        end
        queue_request(FUNC_LOOKUP, 32'h1234_5678, '0);

        // Hold off the sender until the table has answered everything so far.
        while (send_q.size() != 0 || req_bus.valid || owed_q.size() != 0) begin
            @(negedge i_clk);
        end

        @(negedge i_clk);
        queue_random(MAIN_CNT);
        while (send_q.size() != 0) begin
            @(negedge i_clk);
        end
        quiet_tail = 1'b1;
        queue_random(TAIL_CNT);

        while (send_q.size() != 0 || req_bus.valid || owed_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYC) @(negedge i_clk);

        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> double_hash_open_address_table_top.f
+incdir+src
src/dhot_pkg.sv
src/dhot_if.sv
src/dhot_ctrl.sv
src/dhot_dpath.sv
src/double_hash_open_address_table_top.sv
src/dhot_checker.sv
bench/double_hash_open_address_table_top_tb.sv
